>>> rtl/iso_pkg.sv
// Shared types, character codes and calendar helpers for the ISO 8601 timestamp core.
// Used by the parser, the job queue and the seconds calculator; depends on nothing else.
package iso_pkg;

	// Parse position: which character of the timestamp comes next
	typedef enum logic [4:0] {
		P_Y0, P_Y1, P_Y2, P_Y3, P_DASH1, P_MO0, P_MO1, P_DASH2, P_D0, P_D1,
		P_SEP, P_H0, P_H1, P_COL1, P_MI0, P_MI1, P_COL2, P_S0, P_S1, P_DOT, P_FRAC
	} pos_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_Z_UP  = 8'h5A;
	localparam logic [7:0] CH_Z_LO  = 8'h7A;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Day offset of 0000-03-01 shifted by one 400-year era
	localparam logic [24:0] DAY_BIAS = 25'd865565;
	// 2^17 / 25, rounded up; exact for quotients of values below 2600
	localparam logic [23:0] RECIP_25 = 24'd5243;

	// One parsed timestamp handed from the parser to the calculator
	typedef struct packed {
		logic        ok;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} job_t;

	// Days from March 1st to the first of the given month (March-based year)
	function automatic logic [8:0] days_before(input logic [3:0] month);
		logic [8:0] d;
		unique case (month)
			4'd3:    d = 9'd0;
			4'd4:    d = 9'd31;
			4'd5:    d = 9'd61;
			4'd6:    d = 9'd92;
			4'd7:    d = 9'd122;
			4'd8:    d = 9'd153;
			4'd9:    d = 9'd184;
			4'd10:   d = 9'd214;
			4'd11:   d = 9'd245;
			4'd12:   d = 9'd275;
			4'd1:    d = 9'd306;
			4'd2:    d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

>>> rtl/iso_parse.sv
// Character parser: walks the timestamp pattern one character per cycle unless
// stalled, gathers date and time digits and pushes a job per timestamp. Depends on iso_pkg.
module iso_parse import iso_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	input  logic       first_char,
	input  logic       last_char,
	input  logic       q_full,
	output logic       push,
	output job_t       job
);

	pos_t        pos_q, pos_cur, pos_nxt;
	logic        finished_q, finished_nxt;
	logic [13:0] year_q, year_cur, year_nxt;
	logic [6:0]  mon_q, mon_cur, mon_nxt;
	logic [6:0]  day_q, day_cur, day_nxt;
	logic [6:0]  hr_q, hr_cur, hr_nxt;
	logic [6:0]  min_q, min_cur, min_nxt;
	logic [6:0]  sec_q, sec_cur, sec_nxt;

	logic       accepted, busy, digit, is_z, ok, z_end, emit, range_ok;
	logic       ld_year, ld_mon, ld_day, ld_hr, ld_min, ld_sec;
	logic [3:0] dv;

	assign char_stall = q_full;
	assign accepted   = char_valid && !char_stall;
	assign busy       = first_char || !finished_q;

	assign digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign dv    = digit ? 4'(char_code - CH_ZERO) : 4'd0;
	assign is_z  = (char_code == CH_Z_UP) || (char_code == CH_Z_LO);

	// A first character restarts the parse from an empty state
	assign pos_cur  = first_char ? P_Y0 : pos_q;
	assign year_cur = first_char ? 14'd0 : year_q;
	assign mon_cur  = first_char ? 7'd0 : mon_q;
	assign day_cur  = first_char ? 7'd0 : day_q;
	assign hr_cur   = first_char ? 7'd0 : hr_q;
	assign min_cur  = first_char ? 7'd0 : min_q;
	assign sec_cur  = first_char ? 7'd0 : sec_q;

	// Classify the character against the expected pattern position
	always_comb begin
		ok      = 1'b0;
		z_end   = 1'b0;
		ld_year = 1'b0;
		ld_mon  = 1'b0;
		ld_day  = 1'b0;
		ld_hr   = 1'b0;
		ld_min  = 1'b0;
		ld_sec  = 1'b0;
		unique case (pos_cur)
			P_Y0, P_Y1, P_Y2, P_Y3: begin
				ok      = digit;
				ld_year = 1'b1;
			end
			P_DASH1, P_DASH2: ok = (char_code == CH_DASH);
			P_MO0, P_MO1: begin
				ok     = digit;
				ld_mon = 1'b1;
			end
			P_D0, P_D1: begin
				ok     = digit;
				ld_day = 1'b1;
			end
			P_SEP: ok = (char_code == CH_T) || (char_code == CH_SPACE);
			P_H0, P_H1: begin
				ok    = digit;
				ld_hr = 1'b1;
			end
			P_COL1, P_COL2: ok = (char_code == CH_COLON);
			P_MI0, P_MI1: begin
				ok     = digit;
				ld_min = 1'b1;
			end
			P_S0, P_S1: begin
				ok     = digit;
				ld_sec = 1'b1;
			end
			P_DOT: begin
				z_end = is_z;
				ok    = (char_code == CH_DOT);
			end
			P_FRAC: begin
				z_end = is_z;
				ok    = digit;
			end
			default: ok = 1'b0;
		endcase
	end

	assign emit = busy && (z_end || !ok || last_char);

	assign range_ok = (mon_cur >= 7'd1) && (mon_cur <= 7'd12) &&
	                  (day_cur >= 7'd1) && (day_cur <= 7'd31) &&
	                  (hr_cur <= 7'd23) && (min_cur <= 7'd59) && (sec_cur <= 7'd60);

	// Next parse state
	always_comb begin
		pos_nxt      = pos_q;
		finished_nxt = 1'b1;
		year_nxt     = year_q;
		mon_nxt      = mon_q;
		day_nxt      = day_q;
		hr_nxt       = hr_q;
		min_nxt      = min_q;
		sec_nxt      = sec_q;
		if (busy) begin
			finished_nxt = emit;
			if (ok && !z_end) begin
				pos_nxt = (pos_cur == P_FRAC) ? P_FRAC : pos_t'(pos_cur + 5'd1);
			end else begin
				pos_nxt = pos_cur;
			end
			year_nxt = ld_year ? 14'(year_cur * 14'd10 + {10'd0, dv}) : year_cur;
			mon_nxt  = ld_mon ? 7'(mon_cur * 7'd10 + {3'd0, dv}) : mon_cur;
			day_nxt  = ld_day ? 7'(day_cur * 7'd10 + {3'd0, dv}) : day_cur;
			hr_nxt   = ld_hr ? 7'(hr_cur * 7'd10 + {3'd0, dv}) : hr_cur;
			min_nxt  = ld_min ? 7'(min_cur * 7'd10 + {3'd0, dv}) : min_cur;
			sec_nxt  = ld_sec ? 7'(sec_cur * 7'd10 + {3'd0, dv}) : sec_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= P_Y0;
			finished_q <= 1'b1;
			year_q     <= '0;
			mon_q      <= '0;
			day_q      <= '0;
			hr_q       <= '0;
			min_q      <= '0;
			sec_q      <= '0;
		end else if (accepted) begin
			pos_q      <= pos_nxt;
			finished_q <= finished_nxt;
			year_q     <= year_nxt;
			mon_q      <= mon_nxt;
			day_q      <= day_nxt;
			hr_q       <= hr_nxt;
			min_q      <= min_nxt;
			sec_q      <= sec_nxt;
		end
	end

	// Job fields use the values gathered before this character
	assign push       = accepted && emit;
	assign job.ok     = z_end && range_ok;
	assign job.year   = year_cur;
	assign job.month  = mon_cur[3:0];
	assign job.day    = day_cur[4:0];
	assign job.hour   = hr_cur[4:0];
	assign job.minute = min_cur[5:0];
	assign job.second = sec_cur[5:0];

endmodule

>>> rtl/iso_queue.sv
// Short job queue between the parser and the calculator, so each side stalls on
// its own. Depends on iso_pkg for the job type and depth.
module iso_queue import iso_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	input  logic pop,
	output job_t rdata,
	output logic full,
	output logic empty
);

	job_t                mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                do_push, do_pop;

	assign full    = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= QUEUE_AW'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= QUEUE_AW'(rd_q + 1'b1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/iso_calc.sv
// Seconds calculator: four pipeline stages plus an output register turn a job into
// signed Unix seconds with a Gregorian day count. Depends on iso_pkg.
module iso_calc import iso_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  job_t               job,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               valid_res,
	output logic signed [38:0] epoch_seconds
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, res_valid_q;

	logic        ok_s1, ok_s2, ok_s3, ok_s4;
	logic [13:0] yp_s1;
	logic [8:0]  doyd_s1, doyd_s2;
	logic [4:0]  hour_s1;
	logic [5:0]  min_s1, sec_s1;
	logic [21:0] y365_s2;
	logic [11:0] y4_s2;
	logic [23:0] q100p_s2, q400p_s2;
	logic [16:0] hms_s2, hms_s3, hms_s4;
	logic signed [24:0] days_s3;
	logic signed [38:0] days_x, prod_s4;
	logic        valid_res_q;
	logic signed [38:0] epoch_q;

	// Advance the whole pipeline unless a finished result is held
	assign en  = !res_valid_q || !res_stall;
	assign pop = en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			res_valid_q <= v_s4;
		end
	end

	assign days_x = 39'(days_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			// shift the year by one era so the floor divisions see only positive values
			ok_s1   <= job.ok;
			yp_s1   <= 14'(job.year + 14'd400 - {13'd0, (job.month <= 4'd2)});
			doyd_s1 <= 9'(days_before(job.month) + {4'd0, job.day} - 9'd1);
			hour_s1 <= job.hour;
			min_s1  <= job.minute;
			sec_s1  <= job.second;

			ok_s2    <= ok_s1;
			y365_s2  <= {8'd0, yp_s1} * 22'd365;
			y4_s2    <= yp_s1[13:2];
			q100p_s2 <= {12'd0, yp_s1[13:2]} * RECIP_25;
			q400p_s2 <= {14'd0, yp_s1[13:4]} * RECIP_25;
			hms_s2   <= 17'({12'd0, hour_s1} * 17'd3600 + {11'd0, min_s1} * 17'd60 +
			            {11'd0, sec_s1});
			doyd_s2  <= doyd_s1;

			ok_s3   <= ok_s2;
			days_s3 <= $signed(25'({3'd0, y365_s2} + {13'd0, y4_s2} + {20'd0, q400p_s2[21:17]} +
			           {16'd0, doyd_s2} - {18'd0, q100p_s2[23:17]}) - DAY_BIAS);
			hms_s3  <= hms_s2;

			ok_s4   <= ok_s3;
			prod_s4 <= days_x * 39'sd86400;
			hms_s4  <= hms_s3;

			valid_res_q <= ok_s4;
			epoch_q     <= ok_s4 ? prod_s4 + $signed({22'd0, hms_s4}) : '0;
		end
	end

	assign res_valid     = res_valid_q;
	assign valid_res     = valid_res_q;
	assign epoch_seconds = epoch_q;

endmodule

>>> rtl/iso8601_utc_to_epoch_seconds_core.sv
// ISO 8601 UTC timestamp to Unix seconds.
// Input channel (char_valid / char_stall): one text character per word, with
// first_char marking the start of a timestamp and last_char the end of the text.
// Accepted pattern: YYYY-MM-DD, T or space, HH:MM:SS, optional '.' and digits, Z or z.
// Output channel (res_valid / res_stall): one word per timestamp with valid_res and
// the signed seconds since 1970-01-01; epoch_seconds is zero when valid_res is 0.
// A result is produced at the closing Z, at the first bad character, or at a last
// character that leaves the text unfinished; later characters are dropped until the
// next first character.
// Throughput: one character per cycle while char_stall is low; the calculator is a
// four-stage pipeline behind a four-entry job queue.
// A job reaches res_valid through the queue, stages s1 to s4 and the result register.
// When res_stall holds while a result is shown, the result register and the calculator
// freeze; the queue keeps taking jobs until full, then char_stall rises.
// Reset (arst_n low): the parser goes idle awaiting a first character, the queue
// empties and no result is shown.
module iso8601_utc_to_epoch_seconds_core import iso_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         char_code,
	input  logic               first_char,
	input  logic               last_char,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               valid_res,
	output logic signed [38:0] epoch_seconds
);

	job_t job_in, job_out;
	logic push, pop, q_full, q_empty;

	iso_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.first_char (first_char),
		.last_char  (last_char),
		.q_full     (q_full),
		.push       (push),
		.job        (job_in)
	);

	iso_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.pop    (pop),
		.rdata  (job_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	iso_calc u_calc (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.job           (job_out),
		.pop           (pop),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.valid_res     (valid_res),
		.epoch_seconds (epoch_seconds)
	);

endmodule

>>> rtl/iso_chk.sv
// Port-level checks for the timestamp core, attached by the bind below.
// Sees only the top-level ports; depends on nothing else.
module iso_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input logic               valid_res,
	input logic signed [38:0] epoch_seconds
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(valid_res) && $stable(epoch_seconds))
		else $error("result changed while stalled");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !valid_res |-> epoch_seconds == 39'sd0)
		else $error("rejected timestamp carries nonzero seconds");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && valid_res |->
			(epoch_seconds >= -39'sd62167219200) && (epoch_seconds <= 39'sd253402300800))
		else $error("seconds outside years 0000 to 9999");

endmodule

bind iso8601_utc_to_epoch_seconds_core iso_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.valid_res     (valid_res),
	.epoch_seconds (epoch_seconds)
);

>>> bench/iso8601_utc_to_epoch_seconds_core_test.sv
// Self-checking bench for iso8601_utc_to_epoch_seconds_core: streams timestamp text with
// random gaps and result stalls and checks every result word against a behavioral parser.
// Depends on iso_pkg for the parse positions and character codes.
module iso8601_utc_to_epoch_seconds_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import iso_pkg::*;

	localparam int ITEM_TARGET = 1250;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef struct packed {
		logic               ok;
		logic signed [38:0] secs;
	} stamp_word_t;

	class stamp_scoreboard;
		pos_t        parse_at;
		logic [13:0] year_acc;
		logic [6:0]  month_acc, day_acc, hour_acc, min_acc, sec_acc;
		bit          idle;
		stamp_word_t due[$];
		int          errors;

		function new();
			clear_fields();
			idle = 1'b1;
			errors = 0;
		endfunction

		function void clear_fields();
			parse_at = P_Y0;
			year_acc = '0;
			month_acc = '0;
			day_acc = '0;
			hour_acc = '0;
			min_acc = '0;
			sec_acc = '0;
		endfunction

		// Proleptic Gregorian day count relative to 1970-01-01, March-based year
		function longint days_from_epoch(longint yr, longint mo, longint dy);
			longint y, era, yoe, mp, doy, doe;
			y = (mo <= 2) ? yr - 1 : yr;
			era = (y >= 0) ? y / 400 : (y - 399) / 400;
			yoe = y - era * 400;
			mp = (mo > 2) ? mo - 3 : mo + 9;
			doy = (153 * mp + 2) / 5 + dy - 1;
			doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
			return era * 146097 + doe - 719468;
		endfunction

		function void post(bit ok, longint secs);
			stamp_word_t w;
			w.ok = ok;
			w.secs = ok ? secs[38:0] : '0;
			due.push_back(w);
			idle = 1'b1;
		endfunction

		function void close_stamp();
			longint secs;
			if (month_acc < 1 || month_acc > 12 || day_acc < 1 || day_acc > 31 ||
					hour_acc > 23 || min_acc > 59 || sec_acc > 60) begin
				post(1'b0, 0);
			end else begin
				secs = days_from_epoch(longint'(year_acc), longint'(month_acc),
					longint'(day_acc)) * 86400 + longint'(hour_acc) * 3600 +
					longint'(min_acc) * 60 + longint'(sec_acc);
				post(1'b1, secs);
			end
		endfunction

		// Returns 1 when the character reached the parser (not dropped while idle)
		function bit note_char(logic [7:0] c, logic f, logic l);
			bit         is_dig, good;
			logic [3:0] dv;
			is_dig = c >= CH_ZERO && c <= CH_NINE;
			dv = is_dig ? 4'(c - CH_ZERO) : 4'd0;
			good = 1'b1;
			if (f) begin
				clear_fields();
				idle = 1'b0;
			end
			if (idle)
				return 1'b0;
			case (parse_at)
				P_Y0, P_Y1, P_Y2, P_Y3: begin
					good = is_dig;
					year_acc = year_acc * 14'd10 + dv;
				end
				P_DASH1, P_DASH2: good = c == CH_DASH;
				P_MO0, P_MO1: begin
					good = is_dig;
					month_acc = month_acc * 7'd10 + dv;
				end
				P_D0, P_D1: begin
					good = is_dig;
					day_acc = day_acc * 7'd10 + dv;
				end
				P_SEP: good = c == CH_T || c == CH_SPACE;
				P_H0, P_H1: begin
					good = is_dig;
					hour_acc = hour_acc * 7'd10 + dv;
				end
				P_COL1, P_COL2: good = c == CH_COLON;
				P_MI0, P_MI1: begin
					good = is_dig;
					min_acc = min_acc * 7'd10 + dv;
				end
				P_S0, P_S1: begin
					good = is_dig;
					sec_acc = sec_acc * 7'd10 + dv;
				end
				default: begin
					if (c == CH_Z_UP || c == CH_Z_LO) begin
						close_stamp();
						return 1'b1;
					end
					good = (parse_at == P_DOT) ? c == CH_DOT : is_dig;
				end
			endcase
			if (!good) begin
				post(1'b0, 0);
				return 1'b1;
			end
			if (parse_at != P_FRAC)
				parse_at = pos_t'(parse_at + 1);
			// text ends with the parse still open
			if (l)
				post(1'b0, 0);
			return 1'b1;
		endfunction

		function void check_word(logic ok, logic signed [38:0] secs);
			stamp_word_t w;
			if (due.size() == 0) begin
				$display("%0t: unexpected result word valid_res=%0b epoch_seconds=%0d",
					$time, ok, secs);
				errors++;
				return;
			end
			w = due.pop_front();
			if (ok !== w.ok) begin
				$display("%0t: valid_res expected %0b, got %0b", $time, w.ok, ok);
				errors++;
			end
			if (secs !== w.secs) begin
				$display("%0t: epoch_seconds expected %0d, got %0d", $time, w.secs, secs);
				errors++;
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               char_valid = 1'b0;
	logic               char_stall;
	logic [7:0]         char_code = '0;
	logic               first_char = 1'b0;
	logic               last_char = 1'b0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic               valid_res;
	logic signed [38:0] epoch_seconds;

	stamp_scoreboard sb;
	logic [7:0]      text_buf[$];
	int              chars_parsed = 0;
	int              quiet_cycles = 0;
	bit              calm = 1'b0;

	iso8601_utc_to_epoch_seconds_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.first_char(first_char),
		.last_char(last_char),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.valid_res(valid_res),
		.epoch_seconds(epoch_seconds)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic send_char(input logic [7:0] c, input logic f, input logic l);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_valid <= 1'b1;
		char_code <= c;
		first_char <= f;
		last_char <= l;
		do @(posedge clk); while (char_stall !== 1'b0);
		if (sb.note_char(c, f, l))
			chars_parsed++;
		@(negedge clk);
	endtask

	function automatic void push_digits(int v, int n);
		int scale;
		scale = (n == 4) ? 1000 : 10;
		while (scale > 0) begin
			text_buf.push_back(8'(CH_ZERO + (v / scale) % 10));
			scale = scale / 10;
		end
	endfunction

	// Mostly in range, with the bounds, one past them and any two digits now and then
	function automatic int pick_field(int lo, int hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			2: return $urandom_range(0, 99);
			3: return hi + 1;
			4: return (lo > 0) ? lo - 1 : hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	function automatic void build_stamp();
		int yr;
		case ($urandom_range(0, 9))
			0: yr = 0;
			1: yr = 9999;
			2: yr = $urandom_range(1969, 1970);
			default: yr = $urandom_range(0, 9999);
		endcase
		push_digits(yr, 4);
		text_buf.push_back(CH_DASH);
		push_digits(pick_field(1, 12), 2);
		text_buf.push_back(CH_DASH);
		push_digits(pick_field(1, 31), 2);
		text_buf.push_back($urandom_range(0, 1) ? CH_T : CH_SPACE);
		push_digits(pick_field(0, 23), 2);
		text_buf.push_back(CH_COLON);
		push_digits(pick_field(0, 59), 2);
		text_buf.push_back(CH_COLON);
		push_digits(pick_field(0, 60), 2);
		if ($urandom_range(0, 2) == 0) begin
			text_buf.push_back(CH_DOT);
			repeat ($urandom_range(0, 5))
				text_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		end
		text_buf.push_back($urandom_range(0, 1) ? CH_Z_UP : CH_Z_LO);
	endfunction

	task automatic send_text(input int stop, input int restart_at, input bit end_flag);
		for (int i = 0; i < stop; i++)
			send_char(text_buf[i], i == 0 || i == restart_at, end_flag && i == stop - 1);
	endtask

	task automatic load_text(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	task automatic run_stamp();
		int kind, stop, restart_at, n;
		bit end_flag;
		text_buf.delete();
		if ($urandom_range(0, 7) == 0)
			calm = ~calm;
		kind = $urandom_range(0, 9);
		restart_at = -1;
		// abandon a partial prefix, then start over on the real timestamp
		if (kind == 9) begin
			n = $urandom_range(1, 6);
			repeat (n)
				text_buf.push_back($urandom_range(0, 1) ? 8'(CH_ZERO + $urandom_range(0, 9))
					: 8'($urandom_range(0, 255)));
			restart_at = n;
		end
		build_stamp();
		stop = text_buf.size();
		end_flag = $urandom_range(0, 1);
		case (kind)
			6: text_buf[$urandom_range(0, stop - 1)] = 8'($urandom_range(0, 255));
			7: begin
				stop = $urandom_range(1, stop - 1);
				end_flag = 1'b1;
			end
			8: begin
				repeat ($urandom_range(1, 3))
					text_buf.push_back(8'($urandom_range(0, 255)));
				stop = text_buf.size();
			end
			default: ;
		endcase
		send_text(stop, restart_at, end_flag);
	endtask

	// Result side: hold stall for a drawn number of cycles, then wait for a word
	initial begin
		int n;
		forever begin
			@(negedge clk);
			n = calm ? 0 : $urandom_range(0, 19);
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (res_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
			sb.check_word(valid_res, epoch_seconds);
	end

	always @(posedge clk) begin
		if ((char_valid === 1'b1 && char_stall === 1'b0) ||
				(res_valid === 1'b1 && res_stall === 1'b0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[iso8601_utc_to_epoch_seconds_core] ERROR");
			$finish;
		end
	end

	initial begin
		sb = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// smallest timestamp, a dropped word while idle, a NUL, an early end
		load_text("0000-01-01T00:00:00Z");
		send_text(text_buf.size(), -1, 1'b0);
		send_char(CH_T, 1'b0, 1'b1);
		send_char(CH_NUL, 1'b1, 1'b0);
		send_char(CH_NINE, 1'b1, 1'b1);

		while (chars_parsed < ITEM_TARGET)
			run_stamp();
		char_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[iso8601_utc_to_epoch_seconds_core] OK");
		else
			$display("[iso8601_utc_to_epoch_seconds_core] ERROR");
		$finish;
	end

endmodule
